// File: rtl/int64_to_decimal_text_macros.svh
// Assertion macros for the int64_to_decimal_text block.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef INT64_TO_DECIMAL_TEXT_MACROS_SVH
`define INT64_TO_DECIMAL_TEXT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define I64DT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define I64DT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/i64dt_pkg.sv
// Shared constants and types for the int64_to_decimal_text block.
// No dependencies.
`default_nettype none
package i64dt_pkg;
    localparam int NUM_W  = 64;
    localparam int CAP_W  = 7;
    localparam int CHAR_W = 8;
    localparam int LEN_W  = 5;
    localparam int NDIG   = 20;
    localparam int BCD_W  = NDIG * 4;
    localparam int CNT_W  = 6;

    localparam logic [CAP_W-1:0]  CAP_RESET  = 7'd32;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_NONE  = 8'h00;
    localparam logic [LEN_W-1:0]  NDIG_FULL  = 5'd20;

    typedef struct packed {
        logic busy;
        logic done;
    } t_bcd_stat;

    typedef struct packed {
        logic busy;
        logic fail;
    } t_emit_stat;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_TRIM = 4'b0010,
        S_EMIT = 4'b0100,
        S_FAIL = 4'b1000
    } t_emit_state;
endpackage
`default_nettype wire

// File: rtl/i64dt_ifs.sv
// Valid/ready channel interfaces for number requests and text results.
// Depends on i64dt_pkg.
`default_nettype none
interface i64dt_num_if;
    logic                                valid;
    logic                                ready;
    logic signed [i64dt_pkg::NUM_W-1:0] number_in;

    modport source (output valid, output number_in, input ready);
    modport sink   (input valid, input number_in, output ready);
endinterface

interface i64dt_text_if;
    logic                          valid;
    logic                          ready;
    logic [i64dt_pkg::CHAR_W-1:0]  text_char;
    logic                          is_last;
    logic                          conv_ok;
    logic [i64dt_pkg::LEN_W-1:0]   text_length;

    modport source (output valid, output text_char, output is_last, output conv_ok,
                    output text_length, input ready);
    modport sink   (input valid, input text_char, input is_last, input conv_ok,
                    input text_length, output ready);
endinterface
`default_nettype wire

// File: rtl/int64_to_decimal_text.sv
// Top level: signed 64-bit integer to decimal ASCII text, one character per o_text transfer.
// Depends on i64dt_pkg, i64dt_ifs, i64dt_bcd, i64dt_emit and the macros header.
//
//  channel   dir   payload                                        handshake
//  i_num     in    number_in[63:0] signed                         valid/ready
//  o_text    out   text_char[7:0], is_last, conv_ok, text_length  valid/ready
//  cfg       in    i_cfg_wr_data[6:0] buffer_capacity             i_cfg_wr_en
//
// One number at a time: bit-serial BCD conversion of the magnitude, then up to 19
// leading zero digits are dropped, then one character per cycle while o_text is taken.
// A number whose text is not shorter than buffer_capacity is refused with a single
// failure item (is_last set, conv_ok clear).
// Synchronous active-low reset clears control and sets buffer_capacity to 32.
// A stalled output holds; i_num stays not ready until the last character goes.
`default_nettype none
`include "int64_to_decimal_text_macros.svh"
module int64_to_decimal_text (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [i64dt_pkg::CAP_W-1:0]   i_cfg_wr_data,
    i64dt_num_if.sink                          i_num,
    i64dt_text_if.source                       o_text
);
    logic [i64dt_pkg::CAP_W-1:0] r_cap;
    logic                        r_neg;
    logic                        take;
    logic [i64dt_pkg::NUM_W-1:0] mag;
    logic [i64dt_pkg::BCD_W-1:0] bcd;
    i64dt_pkg::t_bcd_stat        bcd_stat;
    i64dt_pkg::t_emit_stat       emit_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= i64dt_pkg::CAP_RESET;
        end else if (i_cfg_wr_en) begin
            r_cap <= i_cfg_wr_data;
        end
    end

    assign i_num.ready = !bcd_stat.busy && !bcd_stat.done && !emit_stat.busy;
    assign take        = i_num.valid && i_num.ready;
    assign mag         = i_num.number_in[i64dt_pkg::NUM_W-1] ?
                         (~i_num.number_in + 1'b1) : i_num.number_in;

    always_ff @(posedge i_clk) begin
        if (take) r_neg <= i_num.number_in[i64dt_pkg::NUM_W-1];
    end

    i64dt_bcd u_bcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (take),
        .i_mag   (mag),
        .o_stat  (bcd_stat),
        .o_bcd   (bcd)
    );

    i64dt_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (bcd_stat.done),
        .i_neg   (r_neg),
        .i_bcd   (bcd),
        .i_cap   (r_cap),
        .o_stat  (emit_stat),
        .o_text  (o_text)
    );

    `I64DT_ASSERT_NEXT(a_take_starts, take, bcd_stat.busy, "request did not start conversion")
    `I64DT_ASSERT_NOW(a_no_overlap, o_text.valid, !i_num.ready, "input ready while text pending")
    `I64DT_ASSERT_NOW(a_fail_last, o_text.valid && emit_stat.fail,
        o_text.is_last && !o_text.conv_ok, "failure result malformed")
    `I64DT_ASSERT_NOW(a_len_fits, o_text.valid && o_text.conv_ok,
        (o_text.text_length != 5'd0) && ({2'b00, o_text.text_length} < r_cap),
        "text length outside buffer")
endmodule
`default_nettype wire

// File: rtl/i64dt_bcd.sv
// Bit-serial binary to BCD converter (shift and add-3), one bit per cycle.
// Depends on i64dt_pkg.
`default_nettype none
module i64dt_bcd (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [i64dt_pkg::NUM_W-1:0]   i_mag,
    output i64dt_pkg::t_bcd_stat               o_stat,
    output logic [i64dt_pkg::BCD_W-1:0]        o_bcd
);
    logic [i64dt_pkg::NUM_W-1:0] r_bin;
    logic [i64dt_pkg::BCD_W-1:0] r_bcd, n_bcd;
    logic [i64dt_pkg::CNT_W-1:0] r_cnt;
    logic                        r_busy, r_done;
    logic [i64dt_pkg::BCD_W-1:0] adj;

    always_comb begin
        for (int d = 0; d < i64dt_pkg::NDIG; d++) begin
            if (r_bcd[d*4 +: 4] >= 4'd5) begin
                adj[d*4 +: 4] = r_bcd[d*4 +: 4] + 4'd3;
            end else begin
                adj[d*4 +: 4] = r_bcd[d*4 +: 4];
            end
        end
        n_bcd = {adj[i64dt_pkg::BCD_W-2:0], r_bin[i64dt_pkg::NUM_W-1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (&r_cnt) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_bin <= i_mag;
            r_bcd <= '0;
        end else if (r_busy) begin
            r_bin <= {r_bin[i64dt_pkg::NUM_W-2:0], 1'b0};
            r_bcd <= n_bcd;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_bcd       = r_bcd;
endmodule
`default_nettype wire

// File: rtl/i64dt_emit.sv
// Text sequencer: drop leading zero digits, check the length, send characters or a failure item.
// Depends on i64dt_pkg and i64dt_text_if.
`default_nettype none
module i64dt_emit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_load,
    input  wire logic                          i_neg,
    input  wire logic [i64dt_pkg::BCD_W-1:0]   i_bcd,
    input  wire logic [i64dt_pkg::CAP_W-1:0]   i_cap,
    output i64dt_pkg::t_emit_stat              o_stat,
    i64dt_text_if.source                       o_text
);
    i64dt_pkg::t_emit_state      r_state;
    logic [i64dt_pkg::BCD_W-1:0] r_digits;
    logic [i64dt_pkg::LEN_W-1:0] r_ndig, r_len, r_left;
    logic                        r_neg, r_sign;
    logic [i64dt_pkg::LEN_W-1:0] len;
    logic                        top_zero, send;

    assign top_zero = (r_digits[i64dt_pkg::BCD_W-1 -: 4] == 4'd0);
    assign len      = r_ndig + {{(i64dt_pkg::LEN_W-1){1'b0}}, r_neg};
    assign send     = o_text.valid && o_text.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= i64dt_pkg::S_IDLE;
        end else begin
            case (r_state)
                i64dt_pkg::S_IDLE: begin
                    if (i_load) r_state <= i64dt_pkg::S_TRIM;
                end
                i64dt_pkg::S_TRIM: begin
                    if (!(top_zero && r_ndig > 5'd1)) begin
                        if ({2'b00, len} >= i_cap) r_state <= i64dt_pkg::S_FAIL;
                        else                       r_state <= i64dt_pkg::S_EMIT;
                    end
                end
                i64dt_pkg::S_EMIT: begin
                    if (send && r_left == 5'd1) r_state <= i64dt_pkg::S_IDLE;
                end
                i64dt_pkg::S_FAIL: begin
                    if (send) r_state <= i64dt_pkg::S_IDLE;
                end
                default: r_state <= i64dt_pkg::S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            i64dt_pkg::S_IDLE: begin
                if (i_load) begin
                    r_digits <= i_bcd;
                    r_neg    <= i_neg;
                    r_ndig   <= i64dt_pkg::NDIG_FULL;
                end
            end
            i64dt_pkg::S_TRIM: begin
                if (top_zero && r_ndig > 5'd1) begin
                    r_digits <= {r_digits[i64dt_pkg::BCD_W-5:0], 4'd0};
                    r_ndig   <= r_ndig - 1'b1;
                end else begin
                    r_len  <= len;
                    r_left <= len;
                    r_sign <= r_neg;
                end
            end
            i64dt_pkg::S_EMIT: begin
                if (send) begin
                    r_left <= r_left - 1'b1;
                    if (r_sign) r_sign <= 1'b0;
                    else        r_digits <= {r_digits[i64dt_pkg::BCD_W-5:0], 4'd0};
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_text.valid       = 1'b0;
        o_text.text_char   = i64dt_pkg::CHAR_NONE;
        o_text.is_last     = 1'b1;
        o_text.conv_ok     = 1'b0;
        o_text.text_length = '0;
        case (r_state)
            i64dt_pkg::S_EMIT: begin
                o_text.valid       = 1'b1;
                o_text.text_char   = r_sign ? i64dt_pkg::CHAR_MINUS :
                    (i64dt_pkg::CHAR_ZERO | {4'h0, r_digits[i64dt_pkg::BCD_W-1 -: 4]});
                o_text.is_last     = (r_left == 5'd1);
                o_text.conv_ok     = 1'b1;
                o_text.text_length = r_len;
            end
            i64dt_pkg::S_FAIL: begin
                o_text.valid = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign o_stat.busy = (r_state != i64dt_pkg::S_IDLE);
    assign o_stat.fail = (r_state == i64dt_pkg::S_FAIL);
endmodule
`default_nettype wire
